@@ rtl/fwl_pkg.sv @@
package fwl_pkg;

  // Table depth default and field widths
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int KEY_W   = 32;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int FREED_W = 7;
  localparam int CFG_W   = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register reset values
  localparam logic [CFG_W-1:0] REQUEST_LIMIT_RST = 16'd60;
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 16'd60;
  localparam logic [CFG_W-1:0] MAX_ENTRY_AGE_RST = 16'd300;

  // Register indexes
  localparam logic [1:0] REG_REQUEST_LIMIT = 2'd0;
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_ENTRY_AGE = 2'd2;

  // Item kinds
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_CLEANUP = 1'b1;

  // Lookup status codes
  localparam logic [1:0] STATUS_EXISTING = 2'd0;
  localparam logic [1:0] STATUS_NEW      = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] request_limit;
    logic [CFG_W-1:0] window_length;
    logic [CFG_W-1:0] max_entry_age;
  } cfg_t;

  // One bucket as stored in the table memory
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  start;
  } entry_t;

  // Result beat, allowed in the lowest bit
  typedef struct packed {
    logic [FREED_W-1:0] freed_entries;
    logic [COUNT_W-1:0] window_count;
    logic [1:0]         lookup_status;
    logic               allowed;
  } res_t;

endpackage

@@ rtl/per_client_fixed_window_limiter.sv @@
// Per-client fixed-window rate limiter.
// Input beats arrive on the s_ channel: s_tuser selects a client request (0)
// or a cleanup sweep (1); s_tdata carries the client key and the time in
// seconds. Each input beat yields exactly one result beat on the m_ channel
// with the allowed flag, lookup status, window count and freed entry count.
// Every item scans the whole bucket table through the single read port of
// the table memory, one entry per cycle, then a request does the
// read-modify-write of its bucket in the update state, which a cleanup
// skips. The engine holds one item at a time: the next item is taken
// once the result of the last has moved to the output register.
// A finished result sits in the output register; the next item is taken and
// scanned while it waits. If the receiver still holds m_tready low when the
// following result is done, that result waits in the engine and s_tready
// stays low until the output register frees up.
// After reset the block writes every table entry empty, one per cycle, with
// s_tready low. The APB registers return to their defaults at once and take
// writes at any time; write them only while idle.
module per_client_fixed_window_limiter #(
  parameter int TABLE_ENTRIES = fwl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] client_key, [63:32] now_seconds
  input  logic [0:0]  s_tuser,   // [0] req_type
  // Result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] allowed, [2:1] lookup_status,
                                 // [18:3] window_count, [25:19] freed_entries
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import fwl_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic [1:0] reg_idx;
  logic       reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.request_limit <= REQUEST_LIMIT_RST;
      cfg.window_length <= WINDOW_LENGTH_RST;
      cfg.max_entry_age <= MAX_ENTRY_AGE_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_REQUEST_LIMIT: cfg.request_limit <= pwdata[CFG_W-1:0];
        REG_WINDOW_LENGTH: cfg.window_length <= pwdata[CFG_W-1:0];
        REG_MAX_ENTRY_AGE: cfg.max_entry_age <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_REQUEST_LIMIT: prdata = {{(32-CFG_W){1'b0}}, cfg.request_limit};
      REG_WINDOW_LENGTH: prdata = {{(32-CFG_W){1'b0}}, cfg.window_length};
      REG_MAX_ENTRY_AGE: prdata = {{(32-CFG_W){1'b0}}, cfg.max_entry_age};
      default:           prdata = '0;
    endcase
  end

  fwl_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser[0]),
    .in_key    (s_tdata[31:0]),
    .in_now    (s_tdata[63:32]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Pack the result beat
  assign m_tdata = {{(32-$bits(res_t)){1'b0}}, res};

endmodule

@@ rtl/fwl_ram.sv @@
module fwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/fwl_engine.sv @@
module fwl_engine #(
  parameter int TABLE_ENTRIES = fwl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fwl_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic [fwl_pkg::KEY_W-1:0] in_key,
  input  logic [fwl_pkg::TIME_W-1:0] in_now,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fwl_pkg::res_t             out_res
);

  import fwl_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW:0]   DEPTH_W   = (AW+1)'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0]      clr_addr;
  logic [AW:0]        issue_addr;
  logic               pend;
  logic [AW-1:0]      pend_addr;
  logic               item_kind;
  logic [KEY_W-1:0]   item_key;
  logic [TIME_W-1:0]  item_now;
  logic               hit_found;
  logic [AW-1:0]      hit_idx;
  logic [COUNT_W-1:0] hit_count;
  logic [TIME_W-1:0]  hit_start;
  logic               free_found;
  logic [AW-1:0]      free_idx;
  logic [FREED_W-1:0] freed;
  res_t               res;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [$bits(entry_t)-1:0] rd_raw;
  entry_t             rd_entry;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_entry;

  logic               accept;
  logic               issue_more;
  logic               scan_last;
  logic               stale;
  logic [TIME_W-1:0]  age;

  logic [COUNT_W-1:0] base_count;
  logic [TIME_W-1:0]  base_start;
  logic [TIME_W-1:0]  elapsed;
  logic               restart;
  logic [COUNT_W-1:0] run_count;
  logic [TIME_W-1:0]  run_start;
  logic [COUNT_W-1:0] new_count;
  logic               can_write;
  logic [AW-1:0]      upd_addr;
  logic [1:0]         upd_status;
  logic               out_free;

  fwl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign issue_more = (issue_addr < DEPTH_W);
  assign scan_last  = pend && (pend_addr == LAST_ADDR);
  assign out_free   = !out_valid || out_ready;

  // Issue reads: address zero on accept, then one per cycle
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (accept) begin
      rd_en = 1'b1;
    end else if (state == ST_SCAN && issue_more) begin
      rd_en   = 1'b1;
      rd_addr = issue_addr[AW-1:0];
    end
  end

  // Cleanup test on the returned bucket
  assign age   = item_now - rd_entry.start;
  assign stale = rd_entry.valid && (age > {{(TIME_W-CFG_W){1'b0}}, cfg.max_entry_age});

  // Request update: pick the bucket, restart the window, count the beat
  always_comb begin
    if (hit_found) begin
      base_count = hit_count;
      base_start = hit_start;
      upd_addr   = hit_idx;
      upd_status = STATUS_EXISTING;
    end else begin
      base_count = '0;
      base_start = item_now;
      upd_addr   = free_idx;
      upd_status = STATUS_NEW;
    end
    can_write = hit_found || free_found;
    elapsed   = item_now - base_start;
    restart   = (elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.window_length});
    run_count = restart ? '0 : base_count;
    run_start = restart ? item_now : base_start;
    new_count = (run_count == COUNT_MAX) ? run_count : run_count + 1'b1;
  end

  // Write port: clearing pass, cleanup invalidation, request write-back
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_entry = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      ST_SCAN: begin
        if (item_kind == KIND_CLEANUP && pend && stale) begin
          wr_en          = 1'b1;
          wr_addr        = pend_addr;
          wr_entry       = rd_entry;
          wr_entry.valid = 1'b0;
        end
      end
      ST_UPDATE: begin
        if (can_write) begin
          wr_en          = 1'b1;
          wr_addr        = upd_addr;
          wr_entry.valid = 1'b1;
          wr_entry.key   = item_key;
          wr_entry.count = new_count;
          wr_entry.start = run_start;
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          state_next = (item_kind == KIND_CLEANUP) ? ST_DONE : ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      pend <= rd_en;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan bookkeeping and result capture
  always_ff @(posedge clk) begin
    pend_addr <= rd_addr;
    if (accept) begin
      item_kind  <= in_kind;
      item_key   <= in_key;
      item_now   <= in_now;
      issue_addr <= (AW+1)'(1);
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      freed      <= '0;
    end else if (state == ST_SCAN) begin
      if (issue_more) begin
        issue_addr <= issue_addr + 1'b1;
      end
      if (pend) begin
        if (item_kind == KIND_CLEANUP) begin
          if (stale) begin
            freed <= freed + 1'b1;
          end
        end else if (rd_entry.valid) begin
          if (!hit_found && rd_entry.key == item_key) begin
            hit_found <= 1'b1;
            hit_idx   <= pend_addr;
            hit_count <= rd_entry.count;
            hit_start <= rd_entry.start;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= pend_addr;
        end
      end
      if (scan_last && item_kind == KIND_CLEANUP) begin
        res <= '{freed_entries: stale ? freed + 1'b1 : freed, window_count: '0,
                 lookup_status: STATUS_EXISTING, allowed: 1'b0};
      end
    end else if (state == ST_UPDATE) begin
      if (can_write) begin
        res <= '{freed_entries: '0, window_count: new_count, lookup_status: upd_status,
                 allowed: (new_count <= cfg.request_limit)};
      end else begin
        res <= '{freed_entries: '0, window_count: '0, lookup_status: STATUS_FULL,
                 allowed: 1'b0};
      end
    end
    if (state == ST_DONE && out_free) begin
      out_res <= res;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fwl_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int BUCKETS      = TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * (TABLE_ENTRIES_DEF + 3);
  localparam int KEY_POOL     = 96;
  localparam int PHASE_ITEMS  = 105;

  typedef enum logic [1:0] {ROW_ITEM, ROW_PINNED, ROW_CFG} row_kind_t;

  // One line of the directed plan: an item, an item with a typed verdict,
  // or a register setting
  typedef struct {
    row_kind_t   row;
    logic        kind;
    logic [31:0] key;
    logic [31:0] now;
    res_t        pinned;
    cfg_t        cfg;
  } plan_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;   // [31:0] client_key, [63:32] now_seconds
  logic [0:0]  s_tuser  = '0;   // [0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [0] allowed, [2:1] lookup_status,
                                // [18:3] window_count, [25:19] freed_entries
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Limiter model state
  cfg_t        model_cfg;
  logic        bucket_used  [BUCKETS];
  logic [31:0] bucket_key   [BUCKETS];
  logic [15:0] bucket_count [BUCKETS];
  logic [31:0] bucket_start [BUCKETS];

  res_t        verdict_q [$];
  plan_row_t   plan [$];
  logic [31:0] key_pool [KEY_POOL];
  logic [31:0] clock_s;
  logic        pin_valid = 1'b0;
  res_t        pin_res   = '0;
  int          items_sent   = 0;
  int          results_seen = 0;
  int          err_count    = 0;
  int          quiet_cycles = 0;
  int          stall_left   = 0;
  int          tx_idle_pct  = 25;
  int          rx_idle_pct  = 45;

  per_client_fixed_window_limiter DUT (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Work out the verdict of one item and update the model buckets
  function automatic res_t predict_verdict(logic kind, logic [31:0] key, logic [31:0] now);
    res_t        v;
    int          hit;
    int          spare;
    logic [6:0]  freed;
    logic [31:0] age_s;
    v = '0;
    hit = -1;
    spare = -1;
    freed = '0;
    if (kind == KIND_CLEANUP) begin
      // free every bucket whose window began too long ago
      for (int i = 0; i < BUCKETS; i++) begin
        age_s = now - bucket_start[i];
        if (bucket_used[i] && age_s > {16'd0, model_cfg.max_entry_age}) begin
          bucket_used[i] = 1'b0;
          freed++;
        end
      end
      v.freed_entries = freed;
      return v;
    end
    // look the key up, note the lowest free bucket
    for (int i = 0; i < BUCKETS; i++) begin
      if (bucket_used[i]) begin
        if (hit < 0 && bucket_key[i] == key) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit < 0) begin
      if (spare < 0) begin
        v.lookup_status = STATUS_FULL;
        return v;
      end
      hit = spare;
      bucket_used[hit]  = 1'b1;
      bucket_key[hit]   = key;
      bucket_count[hit] = '0;
      bucket_start[hit] = now;
      v.lookup_status   = STATUS_NEW;
    end else begin
      v.lookup_status = STATUS_EXISTING;
    end
    // restart an expired window, then count this request
    age_s = now - bucket_start[hit];
    if (age_s >= {16'd0, model_cfg.window_length}) begin
      bucket_count[hit] = '0;
      bucket_start[hit] = now;
    end
    if (bucket_count[hit] != COUNT_MAX) bucket_count[hit]++;
    v.allowed      = (bucket_count[hit] <= model_cfg.request_limit);
    v.window_count = bucket_count[hit];
    return v;
  endfunction

  function automatic plan_row_t item_row(logic kind, logic [31:0] key, logic [31:0] now);
    plan_row_t r;
    r.row    = ROW_ITEM;
    r.kind   = kind;
    r.key    = key;
    r.now    = now;
    r.pinned = '0;
    r.cfg    = '0;
    return r;
  endfunction

  function automatic plan_row_t pinned_row(logic kind, logic [31:0] key, logic [31:0] now,
                                           logic allowed, logic [1:0] status,
                                           logic [15:0] count, logic [6:0] freed);
    plan_row_t r;
    r = item_row(kind, key, now);
    r.row                  = ROW_PINNED;
    r.pinned.allowed       = allowed;
    r.pinned.lookup_status = status;
    r.pinned.window_count  = count;
    r.pinned.freed_entries = freed;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [15:0] lim, logic [15:0] win, logic [15:0] age);
    plan_row_t r;
    r = item_row(KIND_REQUEST, '0, '0);
    r.row = ROW_CFG;
    r.cfg = '{request_limit: lim, window_length: win, max_entry_age: age};
    return r;
  endfunction

  // Offer one beat, sometimes after a random gap, and hold it until taken
  task automatic push_item(input logic kind, input logic [31:0] key, input logic [31:0] now,
                           input logic pin, input res_t pinned);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 80);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= kind;
    s_tdata   <= {now, key};
    pin_valid <= pin;
    pin_res   <= pinned;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Drop valid and wait until every verdict has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_REQUEST_LIMIT: model_cfg.request_limit = value;
      REG_WINDOW_LENGTH: model_cfg.window_length = value;
      REG_MAX_ENTRY_AGE: model_cfg.max_entry_age = value;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    drain_results();
    write_reg(REG_REQUEST_LIMIT, c.request_limit);
    write_reg(REG_WINDOW_LENGTH, c.window_length);
    write_reg(REG_MAX_ENTRY_AGE, c.max_entry_age);
  endtask

  // Mostly small time steps over a mix of hot, pooled and fresh keys
  task automatic run_random_phase(input cfg_t c, input int fresh_pct, input int sweep_pct);
    logic        kind;
    logic [31:0] key;
    logic [31:0] jump;
    int          pick;
    apply_cfg(c);
    repeat (PHASE_ITEMS) begin
      kind = ($urandom_range(99) < sweep_pct) ? KIND_CLEANUP : KIND_REQUEST;
      pick = $urandom_range(99);
      if (pick < fresh_pct) key = $urandom();
      else if (pick < fresh_pct + (100 - fresh_pct) / 2) key = key_pool[$urandom_range(7)];
      else key = key_pool[$urandom_range(KEY_POOL - 1)];
      pick = $urandom_range(99);
      if (pick < 60) jump = $urandom_range(2);
      else if (pick < 85) jump = $urandom_range(32'(model_cfg.window_length) + 2);
      else if (pick < 98) jump = $urandom_range(32'(model_cfg.max_entry_age) + 10);
      else jump = $urandom();
      clock_s = clock_s + jump;
      push_item(kind, key, clock_s, 1'b0, '0);
    end
  endtask

  // Stall the result side in short and long bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < rx_idle_pct) begin
      m_tready   <= 1'b0;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 150) : $urandom_range(3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check result beats, then predict the input beat taken at this edge
  always @(posedge clk) begin : verdict_check
    res_t want;
    res_t got;
    if (rst) begin
      for (int i = 0; i < BUCKETS; i++) bucket_used[i] = 1'b0;
      model_cfg = '{REQUEST_LIMIT_RST, WINDOW_LENGTH_RST, MAX_ENTRY_AGE_RST};
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = res_t'(m_tdata[25:0]);
        if (verdict_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("%0t: result beat with none pending: %h", $realtime,
                                        m_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (got.allowed !== want.allowed || got.lookup_status !== want.lookup_status ||
              got.window_count !== want.window_count ||
              got.freed_entries !== want.freed_entries || m_tdata[31:26] !== '0) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: allowed %0d/%0d status %0d/%0d count %0d/%0d freed %0d/%0d pad %h",
                       $realtime, want.allowed, got.allowed, want.lookup_status,
                       got.lookup_status, want.window_count, got.window_count,
                       want.freed_entries, got.freed_entries, m_tdata[31:26]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_verdict(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
        verdict_q.push_back(pin_valid ? pin_res : want);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = 32'hFFFF_FFFF;
    clock_s = $urandom();

    // default registers: first request, window edge, time wrap, age edge
    plan.push_back(pinned_row(KIND_REQUEST, 32'h0, 32'd0, 1'b1, STATUS_NEW, 16'd1, 7'd0));
    plan.push_back(pinned_row(KIND_REQUEST, 32'h0, 32'd59, 1'b1, STATUS_EXISTING, 16'd2, 7'd0));
    plan.push_back(pinned_row(KIND_REQUEST, 32'h0, 32'd60, 1'b1, STATUS_EXISTING, 16'd1, 7'd0));
    plan.push_back(pinned_row(KIND_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STATUS_NEW,
                              16'd1, 7'd0));
    plan.push_back(pinned_row(KIND_REQUEST, 32'hFFFF_FFFF, 32'd0, 1'b1, STATUS_EXISTING,
                              16'd2, 7'd0));
    plan.push_back(pinned_row(KIND_CLEANUP, 32'hAAAA_5555, 32'd300, 1'b0, STATUS_EXISTING,
                              16'd0, 7'd1));
    plan.push_back(pinned_row(KIND_CLEANUP, 32'h0, 32'd360, 1'b0, STATUS_EXISTING, 16'd0, 7'd0));
    plan.push_back(pinned_row(KIND_CLEANUP, 32'h0, 32'd361, 1'b0, STATUS_EXISTING, 16'd0, 7'd1));
    // limit of one, longest window, zero age
    plan.push_back(cfg_row(16'd1, 16'hFFFF, 16'd0));
    plan.push_back(pinned_row(KIND_REQUEST, 32'h1234_5678, 32'd1000, 1'b1, STATUS_NEW,
                              16'd1, 7'd0));
    plan.push_back(pinned_row(KIND_REQUEST, 32'h1234_5678, 32'd1001, 1'b0, STATUS_EXISTING,
                              16'd2, 7'd0));
    plan.push_back(item_row(KIND_REQUEST, 32'h1234_5678, 32'd66534));
    plan.push_back(pinned_row(KIND_REQUEST, 32'h1234_5678, 32'd66535, 1'b1, STATUS_EXISTING,
                              16'd1, 7'd0));
    plan.push_back(pinned_row(KIND_CLEANUP, 32'h0, 32'd66535, 1'b0, STATUS_EXISTING,
                              16'd0, 7'd0));
    plan.push_back(pinned_row(KIND_CLEANUP, 32'h0, 32'd66536, 1'b0, STATUS_EXISTING,
                              16'd0, 7'd1));
    // zero limit refuses all, zero window restarts on every request
    plan.push_back(cfg_row(16'd0, 16'd0, 16'hFFFF));
    plan.push_back(pinned_row(KIND_REQUEST, 32'h0000_FFFF, 32'd5, 1'b0, STATUS_NEW,
                              16'd1, 7'd0));
    plan.push_back(pinned_row(KIND_REQUEST, 32'h0000_FFFF, 32'd5, 1'b0, STATUS_EXISTING,
                              16'd1, 7'd0));
    plan.push_back(pinned_row(KIND_CLEANUP, 32'h0, 32'd65541, 1'b0, STATUS_EXISTING,
                              16'd0, 7'd1));
    // highest limit, shortest window, wrapped age on cleanup
    plan.push_back(cfg_row(16'hFFFF, 16'd1, 16'hFFFF));
    plan.push_back(pinned_row(KIND_REQUEST, 32'hFFFF_0000, 32'h8000_0000, 1'b1, STATUS_NEW,
                              16'd1, 7'd0));
    plan.push_back(item_row(KIND_REQUEST, 32'hFFFF_0000, 32'h8000_0000));
    plan.push_back(pinned_row(KIND_REQUEST, 32'hFFFF_0000, 32'h8000_0001, 1'b1,
                              STATUS_EXISTING, 16'd1, 7'd0));
    plan.push_back(pinned_row(KIND_CLEANUP, 32'h0, 32'h7FFF_FFFF, 1'b0, STATUS_EXISTING,
                              16'd0, 7'd1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // walk the directed plan
    foreach (plan[i]) begin
      case (plan[i].row)
        ROW_CFG:    apply_cfg(plan[i].cfg);
        ROW_PINNED: push_item(plan[i].kind, plan[i].key, plan[i].now, 1'b1, plan[i].pinned);
        default:    push_item(plan[i].kind, plan[i].key, plan[i].now, 1'b0, '0);
      endcase
    end

    // random phases: sender idles less, then more, then neither side idles
    run_random_phase('{16'd3, 16'd20, 16'd100}, 10, 7);
    run_random_phase('{16'd1, 16'd1, 16'd0}, 10, 7);
    tx_idle_pct = 45;
    rx_idle_pct = 25;
    run_random_phase('{16'($urandom_range(1, 10)), 16'($urandom_range(1, 200)),
                       16'($urandom_range(600))}, 10, 7);
    run_random_phase('{16'hFFFF, 16'hFFFF, 16'hFFFF}, 70, 2);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_phase('{16'd0, 16'd0, 16'($urandom_range(50))}, 10, 7);
    run_random_phase('{16'($urandom_range(1, 6)), 16'($urandom_range(1, 100)),
                       16'($urandom_range(400))}, 20, 7);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
